### hw/rtl/aslu_pkg.sv
// shared types and constants of the address to symbol range lookup
package aslu_pkg;

    localparam logic [1:0] MODE_REGION  = 2'd0;
    localparam logic [1:0] MODE_SYMBOL  = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;

    localparam logic [3:0] SYM_TYPE_NOTYPE = 4'd0;
    localparam logic [3:0] SYM_TYPE_TLS    = 4'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  entry_index;
        logic        entry_valid;
        logic [63:0] address;
        logic [63:0] region_end;
        logic [63:0] symbol_offset;
        logic [31:0] symbol_size;
        logic [3:0]  symbol_region;
        logic [3:0]  symbol_type;
        logic        symbol_named;
        logic        symbol_kind;
    } t_req;

    typedef struct packed {
        logic        region_hit;
        logic [3:0]  region_index;
        logic        symbol_hit;
        logic [9:0]  symbol_index;
        logic [63:0] symbol_start;
        logic [31:0] resolved_size;
        logic        from_debug;
    } t_rsp;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] limit;
    } t_region_entry;

    // usable folds valid, named, type and nonzero size at load time
    typedef struct packed {
        logic [63:0] offset;
        logic [31:0] length;
        logic [3:0]  owner;
        logic        is_debug;
        logic        usable;
    } t_sym_entry;

    typedef struct packed {
        logic        found;
        logic        exact;
        logic [63:0] start;
        logic [31:0] length;
    } t_sym_best;

endpackage

### hw/rtl/aslu_ifs.sv
// request and response channel interfaces of the lookup
interface aslu_req_if;
    import aslu_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface aslu_rsp_if;
    import aslu_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/aslu_ram.sv
// generic single write, single read ram with registered read data
module aslu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/aslu_sym_match.sv
// symbol window test pipeline with best-match tracking per symbol kind
module aslu_sym_match #(
    parameter int IDX_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_vld,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [63:0]         i_offset,
    input  logic [31:0]         i_length,
    input  logic                i_is_debug,
    input  logic [63:0]         i_addr,
    input  logic [63:0]         i_base,
    output logic                o_busy,
    output aslu_pkg::t_sym_best o_dyn,
    output aslu_pkg::t_sym_best o_dbg,
    output logic [IDX_W-1:0]    o_dyn_idx,
    output logic [IDX_W-1:0]    o_dbg_idx
);
    import aslu_pkg::*;

    // stage 1: absolute start at 65 bits
    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_idx;
    logic [64:0]      r_s1_start;
    logic [31:0]      r_s1_len;
    logic             r_s1_dbg;

    // stage 2: window test and distance
    logic             r_s2_vld;
    logic [IDX_W-1:0] r_s2_idx;
    logic [63:0]      r_s2_start;
    logic [31:0]      r_s2_len;
    logic             r_s2_dbg;
    logic [63:0]      r_s2_dist;

    // best per kind, slot 0 dynamic, slot 1 debug
    logic             r_found [2];
    logic [63:0]      r_dist  [2];
    logic [63:0]      r_start [2];
    logic [31:0]      r_len   [2];
    logic [IDX_W-1:0] r_idx   [2];

    logic [64:0] n_s1_start;
    logic [64:0] n_stop;
    logic        n_in_win;
    logic        n_better;

    always_comb begin
        n_s1_start = {1'b0, i_base} + {1'b0, i_offset};
        n_stop     = r_s1_start + {33'd0, r_s1_len};
        n_in_win   = !r_s1_start[64] && (i_addr >= r_s1_start[63:0])
                     && ({1'b0, i_addr} < n_stop);
        n_better   = !r_found[r_s2_dbg] || (r_s2_dist < r_dist[r_s2_dbg]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_found[0] <= 1'b0;
            r_found[1] <= 1'b0;
        end else begin
            r_s1_vld   <= i_vld;
            r_s1_idx   <= i_idx;
            r_s1_start <= n_s1_start;
            r_s1_len   <= i_length;
            r_s1_dbg   <= i_is_debug;

            r_s2_vld   <= r_s1_vld && n_in_win;
            r_s2_idx   <= r_s1_idx;
            r_s2_start <= r_s1_start[63:0];
            r_s2_len   <= r_s1_len;
            r_s2_dbg   <= r_s1_dbg;
            r_s2_dist  <= i_addr - r_s1_start[63:0];

            if (i_clear) begin
                r_found[0] <= 1'b0;
                r_found[1] <= 1'b0;
            end else if (r_s2_vld && n_better) begin
                // strict compare keeps the earliest entry on ties
                r_found[r_s2_dbg] <= 1'b1;
                r_dist[r_s2_dbg]  <= r_s2_dist;
                r_start[r_s2_dbg] <= r_s2_start;
                r_len[r_s2_dbg]   <= r_s2_len;
                r_idx[r_s2_dbg]   <= r_s2_idx;
            end
        end
    end

    assign o_busy = r_s1_vld || r_s2_vld;

    always_comb begin
        o_dyn.found  = r_found[0];
        o_dyn.exact  = (r_dist[0] == 64'd0);
        o_dyn.start  = r_start[0];
        o_dyn.length = r_len[0];
        o_dbg.found  = r_found[1];
        o_dbg.exact  = (r_dist[1] == 64'd0);
        o_dbg.start  = r_start[1];
        o_dbg.length = r_len[1];
        o_dyn_idx    = r_idx[0];
        o_dbg_idx    = r_idx[1];
    end

endmodule

### hw/rtl/address_to_symbol_range_lookup.sv
// address to symbol range lookup top level: tables, scan sequencer, result register
//
//  channel  dir  payload  accepted when
//  i_req    in   t_req    i_req.valid && i_req.ready
//  o_rsp    out  t_rsp    o_rsp.valid && o_rsp.ready
//
// a load is written as it is taken and the lookup stays ready; a resolve holds the input
// while it sweeps the region memory and then the symbol memory, the latter through its
// single read port one entry per cycle, and then drains the match pipeline tail; a region
// miss skips the symbol sweep.
// after reset a clearing pass over every entry zeroes the symbol memory;
// no request is taken during it. reset is synchronous, active low.
// a pending response does not block loads; a resolve waits at its end
// until the response register is free.
module address_to_symbol_range_lookup #(
    parameter int REGIONS = 16,
    parameter int SYMBOLS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aslu_req_if.sink   i_req,
    aslu_rsp_if.source o_rsp
);
    import aslu_pkg::*;

    localparam int RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int SIW   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int RCW   = $clog2(REGIONS + 1);
    localparam int SCW   = $clog2(SYMBOLS + 1);
    localparam int CNT_W = (SCW > RCW) ? SCW : RCW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RSCAN,
        ST_RDEC,
        ST_SSCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_addr;
    logic             r_region_valid [REGIONS];

    logic             r_rrd_vld;
    logic [RIW-1:0]   r_rrd_idx;
    logic             r_srd_vld;
    logic [SIW-1:0]   r_srd_idx;

    logic             r_rany;
    logic             r_rhit;
    logic [RIW-1:0]   r_best_idx;
    logic [63:0]      r_best_base;
    logic [63:0]      r_best_limit;

    logic             r_out_valid;
    t_rsp             r_out;

    logic             n_acc;
    logic             n_reg_we;
    logic             n_sym_we;
    logic [SIW-1:0]   n_sym_waddr;
    t_sym_entry       n_sym_wdata;
    t_region_entry    n_reg_wdata;
    logic             n_reg_re;
    logic             n_sym_re;
    logic             n_match_vld;
    logic             n_take;
    logic             n_use_dyn;
    logic             n_use_dbg;
    t_rsp             n_rsp;

    t_region_entry    reg_rdata;
    t_sym_entry       sym_rdata;
    logic             busy;
    t_sym_best        dyn_best;
    t_sym_best        dbg_best;
    logic [SIW-1:0]   dyn_idx;
    logic [SIW-1:0]   dbg_idx;

    assign i_req.ready = (r_state == ST_IDLE);
    assign n_acc       = i_req.valid && i_req.ready;

    always_comb begin
        n_reg_we = n_acc && (i_req.data.mode == MODE_REGION)
                   && (32'(i_req.data.entry_index[3:0]) < 32'(REGIONS));
        n_reg_wdata.base  = i_req.data.address;
        n_reg_wdata.limit = i_req.data.region_end;

        n_sym_wdata.offset   = i_req.data.symbol_offset;
        n_sym_wdata.length   = i_req.data.symbol_size;
        n_sym_wdata.owner    = i_req.data.symbol_region;
        n_sym_wdata.is_debug = i_req.data.symbol_kind;
        n_sym_wdata.usable   = i_req.data.entry_valid && i_req.data.symbol_named
                               && (i_req.data.symbol_type != SYM_TYPE_NOTYPE)
                               && (i_req.data.symbol_type != SYM_TYPE_TLS)
                               && (i_req.data.symbol_size != 32'd0);
        n_sym_waddr = SIW'(i_req.data.entry_index);
        n_sym_we    = n_acc && (i_req.data.mode == MODE_SYMBOL)
                      && (32'(i_req.data.entry_index) < 32'(SYMBOLS));
        if (r_state == ST_CLEAR) begin
            n_sym_we    = 1'b1;
            n_sym_waddr = r_cnt[SIW-1:0];
            n_sym_wdata = '0;
        end

        n_reg_re    = (r_state == ST_RSCAN) && (r_cnt != CNT_W'(REGIONS));
        n_sym_re    = (r_state == ST_SSCAN) && (r_cnt != CNT_W'(SYMBOLS));
        n_match_vld = r_srd_vld && sym_rdata.usable
                      && (32'(sym_rdata.owner) == 32'(r_best_idx));

        n_take    = !r_out_valid || o_rsp.ready;
        n_use_dyn = r_rhit && dyn_best.found && dyn_best.exact;
        n_use_dbg = r_rhit && !n_use_dyn && dbg_best.found;

        n_rsp = '0;
        n_rsp.region_hit   = r_rhit;
        n_rsp.region_index = r_rhit ? 4'(r_best_idx) : 4'd0;
        n_rsp.symbol_hit   = n_use_dyn || n_use_dbg;
        n_rsp.from_debug   = n_use_dbg;
        if (n_use_dyn) begin
            n_rsp.symbol_index  = 10'(dyn_idx);
            n_rsp.symbol_start  = dyn_best.start;
            n_rsp.resolved_size = dyn_best.length;
        end else if (n_use_dbg) begin
            n_rsp.symbol_index  = 10'(dbg_idx);
            n_rsp.symbol_start  = dbg_best.start;
            n_rsp.resolved_size = dbg_best.length;
        end
    end

    aslu_ram #(
        .WIDTH ($bits(t_region_entry)),
        .DEPTH (REGIONS)
    ) u_region_ram (
        .i_clk   (i_clk),
        .i_we    (n_reg_we),
        .i_waddr (RIW'(i_req.data.entry_index[3:0])),
        .i_wdata (n_reg_wdata),
        .i_re    (n_reg_re),
        .i_raddr (r_cnt[RIW-1:0]),
        .o_rdata (reg_rdata)
    );

    aslu_ram #(
        .WIDTH ($bits(t_sym_entry)),
        .DEPTH (SYMBOLS)
    ) u_symbol_ram (
        .i_clk   (i_clk),
        .i_we    (n_sym_we),
        .i_waddr (n_sym_waddr),
        .i_wdata (n_sym_wdata),
        .i_re    (n_sym_re),
        .i_raddr (r_cnt[SIW-1:0]),
        .o_rdata (sym_rdata)
    );

    aslu_sym_match #(
        .IDX_W (SIW)
    ) u_sym_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (r_state == ST_RDEC),
        .i_vld      (n_match_vld),
        .i_idx      (r_srd_idx),
        .i_offset   (sym_rdata.offset),
        .i_length   (sym_rdata.length),
        .i_is_debug (sym_rdata.is_debug),
        .i_addr     (r_addr),
        .i_base     (r_best_base),
        .o_busy     (busy),
        .o_dyn      (dyn_best),
        .o_dbg      (dbg_best),
        .o_dyn_idx  (dyn_idx),
        .o_dbg_idx  (dbg_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_rrd_vld   <= 1'b0;
            r_srd_vld   <= 1'b0;
            r_rany      <= 1'b0;
            r_rhit      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REGIONS; i++) begin
                r_region_valid[i] <= 1'b0;
            end
        end else begin
            r_rrd_vld <= n_reg_re;
            r_rrd_idx <= r_cnt[RIW-1:0];
            r_srd_vld <= n_sym_re;
            r_srd_idx <= r_cnt[SIW-1:0];

            if (n_reg_we) begin
                r_region_valid[RIW'(i_req.data.entry_index[3:0])] <=
                    i_req.data.entry_valid;
            end

            // region sweep: greatest base at or below the address, lowest entry on ties
            if (r_rrd_vld && r_region_valid[r_rrd_idx] && (reg_rdata.base <= r_addr)
                    && (!r_rany || (reg_rdata.base > r_best_base))) begin
                r_rany       <= 1'b1;
                r_best_idx   <= r_rrd_idx;
                r_best_base  <= reg_rdata.base;
                r_best_limit <= reg_rdata.limit;
            end

            // the done state reloads the register itself
            if (r_out_valid && o_rsp.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SYMBOLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (n_acc && (i_req.data.mode == MODE_RESOLVE)) begin
                        r_addr  <= i_req.data.address;
                        r_cnt   <= '0;
                        r_rany  <= 1'b0;
                        r_state <= ST_RSCAN;
                    end
                end
                ST_RSCAN: begin
                    if (r_cnt != CNT_W'(REGIONS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_state <= ST_RDEC;
                    end
                end
                ST_RDEC: begin
                    r_cnt <= '0;
                    if (r_rany && (r_addr < r_best_limit)) begin
                        r_rhit  <= 1'b1;
                        r_state <= ST_SSCAN;
                    end else begin
                        r_rhit  <= 1'b0;
                        r_state <= ST_DONE;
                    end
                end
                ST_SSCAN: begin
                    if (r_cnt != CNT_W'(SYMBOLS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_srd_vld && !busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (n_take) begin
                        r_out_valid <= 1'b1;
                        r_out       <= n_rsp;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    a_no_table_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSCAN || r_state == ST_SSCAN || r_state == ST_DRAIN)
        |-> (!n_sym_we && !n_reg_we))
        else $error("table written during a resolve sweep");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("response raised outside the done state");

    a_symbol_needs_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.symbol_hit) |-> o_rsp.data.region_hit)
        else $error("symbol hit without region hit");

    a_pipe_empty_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!busy && !r_srd_vld))
        else $error("match pipeline still busy at result time");

    a_region_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSCAN) |-> (r_cnt <= CNT_W'(REGIONS)))
        else $error("region sweep counter out of range");

endmodule
